// ===== sv/gblur_pkg.sv =====
// Shared types and constants for the 3x3 binomial blur with replicated edges.
// No dependencies; every other file of the block imports this package.
package gblur_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 8;
    localparam int CFG_WIDTH_W   = 11;
    localparam int CFG_HEIGHT_W  = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } action_t;

    // Per-word control that travels from the position counters to the window stage.
    typedef struct packed {
        logic drain;
        logic top_from_mid;
        logic col_first;
        logic col_last;
        logic last_row;
    } item_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_in_run;
        logic             end_of_frame;
    } result_t;

endpackage

// ===== sv/gblur_line_store.sv =====
// One row of pixels: single write port, single registered read port, read-first.
// Depends on gblur_pkg for the pixel width.
module gblur_line_store #(
    parameter int MAX_WIDTH = gblur_pkg::MAX_WIDTH_DEF,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [gblur_pkg::PIX_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [gblur_pkg::PIX_W-1:0] rd_data
);
    import gblur_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/gblur_ctrl.sv =====
// Configuration registers and frame position counters (column, row, drain phase).
// Decides per input word whether it does work and builds its control for the window stage.
// Depends on gblur_pkg.
module gblur_ctrl #(
    parameter int MAX_WIDTH = gblur_pkg::MAX_WIDTH_DEF,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  gblur_pkg::cfg_reg_t               cfg_index,
    input  logic [gblur_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              accept,
    input  gblur_pkg::action_t                action,
    output logic                              live,
    output logic                              push,
    output logic [AW-1:0]                     col,
    output gblur_pkg::item_ctl_t              ctl
);
    import gblur_pkg::*;

    // Index of the last column after clamping the register to 1..MAX_WIDTH.
    function automatic logic [AW-1:0] width_last(input logic [CFG_WIDTH_W-1:0] w);
        int v;
        v = int'(w);
        if (v < 1) v = 1;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        return AW'(v - 1);
    endfunction

    logic [AW-1:0]           wlast_reg, wlast_next;
    logic [CFG_HEIGHT_W-1:0] hlast_reg, hlast_next;
    logic                    hmulti_reg, hmulti_next;
    logic [AW-1:0]           col_reg, col_next;
    logic [CFG_HEIGHT_W-1:0] row_reg, row_next;
    logic                    draining_reg, draining_next;
    logic                    is_drain;
    logic                    col_last;

    always_comb begin
        is_drain = (action == ACT_DRAIN);
        live     = is_drain ? draining_reg : !draining_reg;
        push     = live && (is_drain || (row_reg != '0));
        col_last = (col_reg == wlast_reg);

        ctl.drain        = is_drain;
        ctl.top_from_mid = is_drain ? !hmulti_reg : (row_reg[CFG_HEIGHT_W-1:1] == '0);
        ctl.col_first    = (col_reg == '0);
        ctl.col_last     = col_last;
        ctl.last_row     = is_drain;
    end

    assign col = col_reg;

    always_comb begin
        wlast_next    = wlast_reg;
        hlast_next    = hlast_reg;
        hmulti_next   = hmulti_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    wlast_next = width_last(cfg_wdata[CFG_WIDTH_W-1:0]);
                end
                REG_IMAGE_HEIGHT: begin
                    hlast_next  = (cfg_wdata == '0) ? '0 : cfg_wdata - 16'd1;
                    hmulti_next = (cfg_wdata > 16'd1);
                end
                default: begin
                end
            endcase
            col_next      = '0;
            row_next      = '0;
            draining_next = 1'b0;
        end else if (accept && live) begin
            if (!col_last) begin
                col_next = col_reg + AW'(1);
            end else begin
                col_next = '0;
                if (is_drain) begin
                    // The bottom row is flushed; the next frame starts over.
                    row_next      = '0;
                    draining_next = 1'b0;
                end else if (row_reg == hlast_reg) begin
                    draining_next = 1'b1;
                end else begin
                    row_next = row_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg    <= width_last(WIDTH_RESET);
            hlast_reg    <= HEIGHT_RESET - 16'd1;
            hmulti_reg   <= 1'b1;
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
        end else begin
            wlast_reg    <= wlast_next;
            hlast_reg    <= hlast_next;
            hmulti_reg   <= hmulti_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            draining_reg <= draining_next;
        end
    end

endmodule

// ===== sv/gblur_window.sv =====
// Window stage: 3x3 pixel window, column push with edge replication and the blur sums.
// Also writes the upper line store and forwards that write to a same-column read.
// Depends on gblur_pkg.
module gblur_window #(
    parameter int MAX_WIDTH = gblur_pkg::MAX_WIDTH_DEF,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  gblur_pkg::item_ctl_t        ld_ctl,
    input  logic [AW-1:0]               ld_col,
    input  logic [gblur_pkg::PIX_W-1:0] ld_pixel,
    input  logic [gblur_pkg::PIX_W-1:0] mid_rd,
    input  logic [gblur_pkg::PIX_W-1:0] up_rd,
    input  logic                        adv,
    output logic                        busy,
    output logic [1:0]                  res_count,
    output gblur_pkg::result_t          res_a,
    output gblur_pkg::result_t          res_b,
    output logic                        up_wr_en,
    output logic [AW-1:0]               up_wr_addr,
    output logic [gblur_pkg::PIX_W-1:0] up_wr_data
);
    import gblur_pkg::*;

    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    // Weighted sum of one window, centred on column 1, or column 2 at the right edge.
    function automatic logic [PIX_W-1:0] blur(input win_t w, input logic right);
        logic [1:0]  c0;
        logic [1:0]  c1;
        logic [9:0]  term;
        logic [11:0] s;
        c0 = right ? 2'd1 : 2'd0;
        c1 = right ? 2'd2 : 2'd1;
        s  = '0;
        for (int r = 0; r < 3; r++) begin
            term = 10'(w[r][c0]) + {1'b0, w[r][c1], 1'b0} + 10'(w[r][2]);
            s = s + ((r == 1) ? {1'b0, term, 1'b0} : 12'(term));
        end
        return s[11:4];
    endfunction

    logic                valid_reg, valid_next;
    item_ctl_t           ctl_reg;
    logic [AW-1:0]       col_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic                fwd_reg;
    logic [PIX_W-1:0]    fwd_data_reg;
    win_t                win_reg, win_next;
    logic [2:0][PIX_W-1:0] v;
    logic [PIX_W-1:0]    up_eff;
    result_t             r_left, r_right;

    assign up_wr_en   = valid_reg && adv && !ctl_reg.drain;
    assign up_wr_addr = col_reg;
    assign up_wr_data = mid_rd;
    assign busy       = valid_reg;

    always_comb begin
        up_eff = fwd_reg ? fwd_data_reg : up_rd;
        v[0]   = ctl_reg.top_from_mid ? mid_rd : up_eff;
        v[1]   = mid_rd;
        v[2]   = ctl_reg.drain ? mid_rd : pix_reg;
        for (int r = 0; r < 3; r++) begin
            if (ctl_reg.col_first) begin
                win_next[r][0] = v[r];
                win_next[r][1] = v[r];
            end else begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[r][2] = v[r];
        end

        r_left.pixel         = blur(win_next, 1'b0);
        r_left.last_in_run   = !ctl_reg.col_last;
        r_left.end_of_frame  = 1'b0;
        r_right.pixel        = blur(win_next, 1'b1);
        r_right.last_in_run  = 1'b1;
        r_right.end_of_frame = ctl_reg.last_row;

        res_a     = ctl_reg.col_first ? r_right : r_left;
        res_b     = r_right;
        res_count = 2'(!ctl_reg.col_first) + 2'(ctl_reg.col_last);

        valid_next = load ? 1'b1 : (adv ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ctl_reg      <= ld_ctl;
            col_reg      <= ld_col;
            pix_reg      <= ld_pixel;
            // The upper store is read at the same edge it is written; take the new value.
            fwd_reg      <= up_wr_en && (ld_col == col_reg);
            fwd_data_reg <= mid_rd;
        end
        if (valid_reg && adv) begin
            win_reg <= win_next;
        end
    end

endmodule

// ===== sv/gblur_out_buf.sv =====
// Two-entry result buffer that takes up to two results per cycle and hands out one word.
// Depends on gblur_pkg for the result type.
module gblur_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_count,
    input  gblur_pkg::result_t push_a,
    input  gblur_pkg::result_t push_b,
    output logic [1:0]         count,
    output logic               m_valid,
    input  logic               m_ready,
    output gblur_pkg::result_t head
);
    import gblur_pkg::*;

    result_t    ent_reg [2];
    result_t    ent_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] kept;
    logic       pop;

    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign head    = ent_reg[0];
    assign count   = cnt_reg;

    always_comb begin
        if (pop) begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[1];
            kept        = cnt_reg - 2'd1;
        end else begin
            ent_next[0] = ent_reg[0];
            ent_next[1] = ent_reg[1];
            kept        = cnt_reg;
        end
        // The caller only pushes when kept plus push_count fits in two entries.
        if (push_count != 2'd0) begin
            ent_next[kept[0]] = push_a;
        end
        if (push_count == 2'd2) begin
            ent_next[1] = push_b;
        end
        cnt_next = kept + push_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

endmodule

// ===== sv/gaussian_blur_3x3_clamp_edge_unit.sv =====
// Streaming 3x3 binomial blur with replicated edges over two line stores.
// Path: the window stage registers an accepted word; the output buffer then holds its results.
// Throughput: one word per cycle while m_ready stays high; a row-end word with two results
// can hold off s_ready while the single result port drains the two-entry output buffer.
// Reset: position counters cleared, width and height set to 1024; line stores are not cleared.
module gaussian_blur_3x3_clamp_edge_unit #(
    parameter int MAX_WIDTH = gblur_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gblur_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gblur_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [gblur_pkg::PIX_W-1:0]         s_pixel_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gblur_pkg::PIX_W-1:0]         m_pixel_out,
    output logic                                m_last_in_run,
    output logic                                m_end_of_frame
);
    import gblur_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic             accept;
    logic             live;
    logic             push;
    logic             load;
    logic [AW-1:0]    col;
    item_ctl_t        ctl;
    logic [PIX_W-1:0] mid_rd;
    logic [PIX_W-1:0] up_rd;
    logic             busy;
    logic             adv;
    logic [1:0]       res_count;
    result_t          res_a, res_b;
    logic             up_wr_en;
    logic [AW-1:0]    up_wr_addr;
    logic [PIX_W-1:0] up_wr_data;
    logic [1:0]       buf_count;
    result_t          head;

    // The window stage moves on when its results fit beside what the buffer already holds.
    assign adv     = busy && ((3'(buf_count) + 3'(res_count)) <= 3'd2);
    assign s_ready = !busy || adv;
    assign accept  = s_valid && s_ready;
    assign load    = accept && push;

    gblur_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_reg_t'(cfg_index)),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .action    (action_t'(s_action)),
        .live      (live),
        .push      (push),
        .col       (col),
        .ctl       (ctl)
    );

    gblur_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_middle_store (
        .aclk    (aclk),
        .wr_en   (accept && live && !ctl.drain),
        .wr_addr (col),
        .wr_data (s_pixel_in),
        .rd_en   (load),
        .rd_addr (col),
        .rd_data (mid_rd)
    );

    gblur_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_upper_store (
        .aclk    (aclk),
        .wr_en   (up_wr_en),
        .wr_addr (up_wr_addr),
        .wr_data (up_wr_data),
        .rd_en   (load),
        .rd_addr (col),
        .rd_data (up_rd)
    );

    gblur_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .ld_ctl     (ctl),
        .ld_col     (col),
        .ld_pixel   (s_pixel_in),
        .mid_rd     (mid_rd),
        .up_rd      (up_rd),
        .adv        (adv),
        .busy       (busy),
        .res_count  (res_count),
        .res_a      (res_a),
        .res_b      (res_b),
        .up_wr_en   (up_wr_en),
        .up_wr_addr (up_wr_addr),
        .up_wr_data (up_wr_data)
    );

    gblur_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (adv ? res_count : 2'd0),
        .push_a     (res_a),
        .push_b     (res_b),
        .count      (buf_count),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    assign m_pixel_out    = head.pixel;
    assign m_last_in_run  = head.last_in_run;
    assign m_end_of_frame = head.end_of_frame;

endmodule
